>>> rtl/core/kpsf_pkg.sv
// shared types, constants and helpers for the position and speed filter
package kpsf_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int PREDICT_GAIN = 10;
  localparam int QW           = 32;
  localparam int CW           = 31;

  localparam logic signed [QW-1:0] Q_ONE = QW'(64'sd1 <<< FRAC_BITS);
  localparam logic [CW-1:0] Q_POS_RST    = CW'(64'd1 << (FRAC_BITS - 1));
  localparam logic [CW-1:0] Q_SPD_RST    = CW'(64'd1 << (FRAC_BITS + 1));
  localparam logic signed [QW-1:0] S_MAX = 32'sh7fffffff;
  localparam logic signed [QW-1:0] S_MIN = 32'sh80000000;

  localparam logic [1:0] OP_PREDICT = 2'd0;
  localparam logic [1:0] OP_UPD_POS = 2'd1;
  localparam logic [1:0] OP_UPD_SPD = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic CFG_Q_POS = 1'b0;
  localparam logic CFG_Q_SPD = 1'b1;

  // datapath register file addresses
  typedef enum logic [3:0] {
    R_POS, R_SPD, R_PP, R_PS, R_SP, R_SS,
    R_A, R_B, R_C, R_D, R_E, R_F, R_G, R_H
  } reg_t;

  typedef enum logic [2:0] {
    U_MUL, U_ADD, U_SUB, U_DIV, U_MOV, U_DBL, U_GAIN, U_NONE
  } uop_t;

  typedef enum logic [2:0] {
    S_REG, S_VAL, S_DT, S_RN, S_ONE, S_QPOS, S_QSPD
  } src_t;

  typedef struct packed {
    logic  go;
    uop_t  uop;
    src_t  sa;
    reg_t  ra;
    src_t  sb;
    reg_t  rb;
    reg_t  rd;
    logic  latch;
    logic  sat_clr;
    logic  s_test;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic s_zero;
  } stat_t;

  function automatic logic signed [QW-1:0] sat64(input logic signed [65:0] x);
    if (x > 66'sh7fffffff) sat64 = S_MAX;
    else if (x < -66'sh80000000) sat64 = S_MIN;
    else sat64 = x[QW-1:0];
  endfunction

  function automatic logic clip64(input logic signed [65:0] x);
    clip64 = (x > 66'sh7fffffff) || (x < -66'sh80000000);
  endfunction

endpackage

>>> rtl/core/kpsf_div.sv
// restoring divider: signed quotient (num << FRAC_BITS) / den, truncated
module kpsf_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [kpsf_pkg::QW-1:0]    num,
  input  logic signed [kpsf_pkg::QW-1:0]    den,
  output logic                              done,
  output logic signed [65:0]                quo
);
  localparam int NW = kpsf_pkg::QW + kpsf_pkg::FRAC_BITS;

  logic [NW-1:0] q_r, q_nxt;
  logic [kpsf_pkg::QW:0] rem_r, rem_nxt;
  logic [kpsf_pkg::QW-1:0] d_r, d_nxt;
  logic neg_r, neg_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic run_r, run_nxt;
  logic [kpsf_pkg::QW:0] trial;
  logic [kpsf_pkg::QW-1:0] na, da;

  always_comb begin
    na = num[kpsf_pkg::QW-1] ? kpsf_pkg::QW'(-num) : kpsf_pkg::QW'(num);
    da = den[kpsf_pkg::QW-1] ? kpsf_pkg::QW'(-den) : kpsf_pkg::QW'(den);
    trial = {rem_r[kpsf_pkg::QW-1:0], q_r[NW-1]} - {1'b0, d_r};
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; neg_nxt = neg_r;
    cnt_nxt = cnt_r; run_nxt = run_r; done = 1'b0;
    if (start) begin
      q_nxt = {na, {kpsf_pkg::FRAC_BITS{1'b0}}};
      rem_nxt = '0; d_nxt = da;
      neg_nxt = num[kpsf_pkg::QW-1] ^ den[kpsf_pkg::QW-1];
      cnt_nxt = 6'(NW); run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[kpsf_pkg::QW]) begin
        rem_nxt = trial; q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[kpsf_pkg::QW-1:0], q_r[NW-1]};
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) run_nxt = 1'b0;
    end else if (cnt_r == 6'd0) begin
      done = 1'b0;
    end
    done = run_r && (cnt_r == 6'd1);
  end

  always_comb begin
    if (neg_r) quo = -$signed({2'b00, q_nxt[NW-1:0]});
    else quo = $signed({2'b00, q_nxt[NW-1:0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt; neg_r <= neg_nxt;
  end
endmodule

>>> rtl/core/kpsf_datapath.sv
// register file, multiplier, adder and divider of the filter
module kpsf_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kpsf_pkg::cmd_t                  cmd,
  input  logic signed [kpsf_pkg::QW-1:0]  val,
  input  logic [kpsf_pkg::QW-1:0]         dt,
  input  logic [kpsf_pkg::QW-1:0]         rn,
  input  logic [kpsf_pkg::CW-1:0]         q_pos,
  input  logic [kpsf_pkg::CW-1:0]         q_spd,
  output kpsf_pkg::stat_t                 stat,
  output logic signed [kpsf_pkg::QW-1:0]  o_pos,
  output logic signed [kpsf_pkg::QW-1:0]  o_spd,
  output logic signed [kpsf_pkg::QW-1:0]  o_pp,
  output logic signed [kpsf_pkg::QW-1:0]  o_ss,
  output logic                            o_clip
);
  logic signed [kpsf_pkg::QW-1:0] rf_r [14];
  logic signed [kpsf_pkg::QW:0] a, b;
  logic signed [65:0] prod, res;
  logic signed [65:0] dq;
  logic clip_r, clip_nxt, wr, ddone, dbusy_r, szero_r;
  logic dstart, dzero;
  kpsf_pkg::reg_t drd_r;

  function automatic logic signed [kpsf_pkg::QW:0] pick(
      input kpsf_pkg::src_t s, input logic signed [kpsf_pkg::QW-1:0] r,
      input logic signed [kpsf_pkg::QW-1:0] v, input logic [kpsf_pkg::QW-1:0] t,
      input logic [kpsf_pkg::QW-1:0] n, input logic [kpsf_pkg::CW-1:0] qp,
      input logic [kpsf_pkg::CW-1:0] qs);
    case (s)
      kpsf_pkg::S_REG:  pick = {r[kpsf_pkg::QW-1], r};
      kpsf_pkg::S_VAL:  pick = {v[kpsf_pkg::QW-1], v};
      kpsf_pkg::S_DT:   pick = {1'b0, t};
      kpsf_pkg::S_RN:   pick = {1'b0, n};
      kpsf_pkg::S_ONE:  pick = {1'b0, kpsf_pkg::Q_ONE};
      kpsf_pkg::S_QPOS: pick = {2'b00, qp};
      kpsf_pkg::S_QSPD: pick = {2'b00, qs};
      default:          pick = '0;
    endcase
  endfunction

  kpsf_div u_div (
    .clk(clk), .rst_n(rst_n),
    .start(dstart),
    .num(rf_r[cmd.ra]), .den(rf_r[cmd.rb]), .done(ddone), .quo(dq)
  );

  always_comb begin
    dzero = cmd.go && cmd.uop == kpsf_pkg::U_DIV && rf_r[cmd.rb] == '0;
    dstart = cmd.go && cmd.uop == kpsf_pkg::U_DIV && !dzero;
    a = pick(cmd.sa, rf_r[cmd.ra], val, dt, rn, q_pos, q_spd);
    b = pick(cmd.sb, rf_r[cmd.rb], val, dt, rn, q_pos, q_spd);
    prod = 66'(a * b);
    wr = cmd.go;
    case (cmd.uop)
      kpsf_pkg::U_MUL:  res = prod >>> kpsf_pkg::FRAC_BITS;
      kpsf_pkg::U_ADD:  res = 66'(a) + 66'(b);
      kpsf_pkg::U_SUB:  res = 66'(a) - 66'(b);
      kpsf_pkg::U_MOV:  res = 66'(a);
      kpsf_pkg::U_DBL:  res = 66'(a) + 66'(a);
      kpsf_pkg::U_GAIN: res = 66'(a) * 66'(kpsf_pkg::PREDICT_GAIN);
      default: begin res = '0; wr = 1'b0; end
    endcase
    if (cmd.uop == kpsf_pkg::U_DIV) wr = 1'b0;
    clip_nxt = clip_r;
    if (cmd.sat_clr) clip_nxt = 1'b0;
    else if (wr && kpsf_pkg::clip64(res)) clip_nxt = 1'b1;
    else if (dzero) clip_nxt = 1'b1;
    else if (ddone && kpsf_pkg::clip64(dq)) clip_nxt = 1'b1;
    if (cmd.s_test && szero_r) clip_nxt = 1'b1;
    stat.busy = dbusy_r && !ddone;
    stat.s_zero = szero_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_r[kpsf_pkg::R_POS] <= '0;
      rf_r[kpsf_pkg::R_SPD] <= '0;
      rf_r[kpsf_pkg::R_PP] <= kpsf_pkg::Q_ONE;
      rf_r[kpsf_pkg::R_PS] <= '0;
      rf_r[kpsf_pkg::R_SP] <= '0;
      rf_r[kpsf_pkg::R_SS] <= kpsf_pkg::Q_ONE;
      clip_r <= 1'b0;
      dbusy_r <= 1'b0;
      szero_r <= 1'b0;
    end else begin
      clip_r <= clip_nxt;
      if (wr) rf_r[cmd.rd] <= kpsf_pkg::sat64(res);
      if (cmd.go && cmd.uop == kpsf_pkg::U_DIV) begin
        dbusy_r <= dstart;
        drd_r <= cmd.rd;
        if (dzero) rf_r[cmd.rd] <= '0;
      end else if (ddone) begin
        dbusy_r <= 1'b0;
        rf_r[drd_r] <= kpsf_pkg::sat64(dq);
      end
      if (cmd.latch) szero_r <= rf_r[cmd.ra] == '0;
    end
  end

  assign o_pos  = rf_r[kpsf_pkg::R_POS];
  assign o_spd  = rf_r[kpsf_pkg::R_SPD];
  assign o_pp   = rf_r[kpsf_pkg::R_PP];
  assign o_ss   = rf_r[kpsf_pkg::R_SS];
  assign o_clip = clip_r;
endmodule

>>> rtl/core/kpsf_ctrl.sv
// sequencer that steps the datapath through one operation
module kpsf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         op,
  input  kpsf_pkg::stat_t    stat,
  output kpsf_pkg::cmd_t     cmd,
  output logic               idle,
  output logic               finish
);
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_RUN = 4'b0010, ST_WAIT = 4'b0100, ST_DONE = 4'b1000
  } state_t;

  state_t st_r, st_nxt;
  logic [4:0] pc_r, pc_nxt;
  logic [1:0] op_r, op_nxt;
  logic last, isdiv;

  function automatic kpsf_pkg::cmd_t mk(input kpsf_pkg::uop_t u,
      input kpsf_pkg::src_t sa, input kpsf_pkg::reg_t ra,
      input kpsf_pkg::src_t sb, input kpsf_pkg::reg_t rb,
      input kpsf_pkg::reg_t rd);
    mk = '{go: 1'b1, uop: u, sa: sa, ra: ra, sb: sb, rb: rb, rd: rd,
           latch: 1'b0, sat_clr: 1'b0, s_test: 1'b0};
  endfunction

  // micro program; A..H are scratch
  always_comb begin
    cmd = '0; cmd.uop = kpsf_pkg::U_NONE; last = 1'b0;
    case (op_r)
      kpsf_pkg::OP_PREDICT: begin
        case (pc_r)
          5'd0: cmd = mk(kpsf_pkg::U_GAIN, kpsf_pkg::S_DT, kpsf_pkg::R_A,
                         kpsf_pkg::S_DT, kpsf_pkg::R_A, kpsf_pkg::R_A);
          5'd1: cmd = mk(kpsf_pkg::U_MUL, kpsf_pkg::S_REG, kpsf_pkg::R_A,
                         kpsf_pkg::S_REG, kpsf_pkg::R_PS, kpsf_pkg::R_B);
          5'd2: cmd = mk(kpsf_pkg::U_DBL, kpsf_pkg::S_REG, kpsf_pkg::R_B,
                         kpsf_pkg::S_REG, kpsf_pkg::R_B, kpsf_pkg::R_B);
          5'd3: cmd = mk(kpsf_pkg::U_MUL, kpsf_pkg::S_REG, kpsf_pkg::R_A,
                         kpsf_pkg::S_REG, kpsf_pkg::R_A, kpsf_pkg::R_C);
          5'd4: cmd = mk(kpsf_pkg::U_MUL, kpsf_pkg::S_REG, kpsf_pkg::R_C,
                         kpsf_pkg::S_REG, kpsf_pkg::R_SS, kpsf_pkg::R_C);
          5'd5: cmd = mk(kpsf_pkg::U_MUL, kpsf_pkg::S_REG, kpsf_pkg::R_A,
                         kpsf_pkg::S_REG, kpsf_pkg::R_SS, kpsf_pkg::R_D);
          5'd6: cmd = mk(kpsf_pkg::U_MUL, kpsf_pkg::S_DT, kpsf_pkg::R_A,
                         kpsf_pkg::S_VAL, kpsf_pkg::R_A, kpsf_pkg::R_E);
          5'd7: cmd = mk(kpsf_pkg::U_ADD, kpsf_pkg::S_REG, kpsf_pkg::R_POS,
                         kpsf_pkg::S_REG, kpsf_pkg::R_E, kpsf_pkg::R_POS);
          5'd8: cmd = mk(kpsf_pkg::U_ADD, kpsf_pkg::S_REG, kpsf_pkg::R_PP,
                         kpsf_pkg::S_REG, kpsf_pkg::R_B, kpsf_pkg::R_PP);
          5'd9: cmd = mk(kpsf_pkg::U_ADD, kpsf_pkg::S_REG, kpsf_pkg::R_PP,
                         kpsf_pkg::S_REG, kpsf_pkg::R_C, kpsf_pkg::R_PP);
          5'd10: cmd = mk(kpsf_pkg::U_ADD, kpsf_pkg::S_REG, kpsf_pkg::R_PP,
                          kpsf_pkg::S_QPOS, kpsf_pkg::R_A, kpsf_pkg::R_PP);
          5'd11: cmd = mk(kpsf_pkg::U_ADD, kpsf_pkg::S_REG, kpsf_pkg::R_PS,
                          kpsf_pkg::S_REG, kpsf_pkg::R_D, kpsf_pkg::R_PS);
          5'd12: cmd = mk(kpsf_pkg::U_ADD, kpsf_pkg::S_REG, kpsf_pkg::R_SP,
                          kpsf_pkg::S_REG, kpsf_pkg::R_D, kpsf_pkg::R_SP);
          5'd13: begin
            cmd = mk(kpsf_pkg::U_ADD, kpsf_pkg::S_REG, kpsf_pkg::R_SS,
                     kpsf_pkg::S_QSPD, kpsf_pkg::R_A, kpsf_pkg::R_SS);
            last = 1'b1;
          end
          default: last = 1'b1;
        endcase
      end
      kpsf_pkg::OP_UPD_POS, kpsf_pkg::OP_UPD_SPD: begin
        logic pm;
        kpsf_pkg::reg_t est, cv, k0n, k1n;
        pm = (op_r == kpsf_pkg::OP_UPD_POS);
        est = pm ? kpsf_pkg::R_POS : kpsf_pkg::R_SPD;
        cv = pm ? kpsf_pkg::R_PP : kpsf_pkg::R_SS;
        k0n = pm ? kpsf_pkg::R_PP : kpsf_pkg::R_PS;
        k1n = pm ? kpsf_pkg::R_SP : kpsf_pkg::R_SS;
        case (pc_r)
          5'd0: cmd = mk(kpsf_pkg::U_SUB, kpsf_pkg::S_VAL, kpsf_pkg::R_A,
                         kpsf_pkg::S_REG, est, kpsf_pkg::R_A);
          5'd1: cmd = mk(kpsf_pkg::U_ADD, kpsf_pkg::S_REG, cv,
                         kpsf_pkg::S_RN, kpsf_pkg::R_A, kpsf_pkg::R_B);
          5'd2: begin
            cmd = '0; cmd.uop = kpsf_pkg::U_NONE;
            cmd.ra = kpsf_pkg::R_B; cmd.latch = 1'b1;
          end
          5'd3: cmd = mk(kpsf_pkg::U_DIV, kpsf_pkg::S_REG, k0n,
                         kpsf_pkg::S_REG, kpsf_pkg::R_B, kpsf_pkg::R_C);
          5'd4: cmd = mk(kpsf_pkg::U_DIV, kpsf_pkg::S_REG, k1n,
                         kpsf_pkg::S_REG, kpsf_pkg::R_B, kpsf_pkg::R_D);
          5'd5: cmd = mk(kpsf_pkg::U_MUL, kpsf_pkg::S_REG, kpsf_pkg::R_C,
                         kpsf_pkg::S_REG, kpsf_pkg::R_A, kpsf_pkg::R_E);
          5'd6: cmd = mk(kpsf_pkg::U_ADD, kpsf_pkg::S_REG, kpsf_pkg::R_POS,
                         kpsf_pkg::S_REG, kpsf_pkg::R_E, kpsf_pkg::R_POS);
          5'd7: cmd = mk(kpsf_pkg::U_MUL, kpsf_pkg::S_REG, kpsf_pkg::R_D,
                         kpsf_pkg::S_REG, kpsf_pkg::R_A, kpsf_pkg::R_E);
          5'd8: cmd = mk(kpsf_pkg::U_ADD, kpsf_pkg::S_REG, kpsf_pkg::R_SPD,
                         kpsf_pkg::S_REG, kpsf_pkg::R_E, kpsf_pkg::R_SPD);
          // F,G,H hold new pp, ps, sp; then ss in place
          5'd9: begin
            if (pm) begin
              cmd = mk(kpsf_pkg::U_SUB, kpsf_pkg::S_ONE, kpsf_pkg::R_A,
                       kpsf_pkg::S_REG, kpsf_pkg::R_C, kpsf_pkg::R_E);
              cmd.s_test = 1'b1;
            end else
              cmd = mk(kpsf_pkg::U_MUL, kpsf_pkg::S_REG, kpsf_pkg::R_C,
                       kpsf_pkg::S_REG, kpsf_pkg::R_PS, kpsf_pkg::R_F);
          end
          5'd10: begin
            if (pm) begin
              if (stat.s_zero) cmd = mk(kpsf_pkg::U_MOV, kpsf_pkg::S_REG,
                kpsf_pkg::R_PP, kpsf_pkg::S_REG, kpsf_pkg::R_A, kpsf_pkg::R_F);
              else cmd = mk(kpsf_pkg::U_MUL, kpsf_pkg::S_REG, kpsf_pkg::R_E,
                kpsf_pkg::S_REG, kpsf_pkg::R_PP, kpsf_pkg::R_F);
            end else
              cmd = mk(kpsf_pkg::U_SUB, kpsf_pkg::S_REG, kpsf_pkg::R_PP,
                       kpsf_pkg::S_REG, kpsf_pkg::R_F, kpsf_pkg::R_F);
          end
          5'd11: begin
            if (pm) begin
              if (stat.s_zero) cmd = mk(kpsf_pkg::U_MOV, kpsf_pkg::S_REG,
                kpsf_pkg::R_PS, kpsf_pkg::S_REG, kpsf_pkg::R_A, kpsf_pkg::R_G);
              else cmd = mk(kpsf_pkg::U_MUL, kpsf_pkg::S_REG, kpsf_pkg::R_E,
                kpsf_pkg::S_REG, kpsf_pkg::R_PS, kpsf_pkg::R_G);
            end else
              cmd = mk(kpsf_pkg::U_MUL, kpsf_pkg::S_REG, kpsf_pkg::R_C,
                       kpsf_pkg::S_REG, kpsf_pkg::R_SS, kpsf_pkg::R_G);
          end
          5'd12: begin
            if (pm) cmd = mk(kpsf_pkg::U_MOV, kpsf_pkg::S_REG, kpsf_pkg::R_PS,
                kpsf_pkg::S_REG, kpsf_pkg::R_A, kpsf_pkg::R_G);
            else cmd = mk(kpsf_pkg::U_SUB, kpsf_pkg::S_REG, kpsf_pkg::R_PS,
                kpsf_pkg::S_REG, kpsf_pkg::R_G, kpsf_pkg::R_G);
            if (pm) cmd.go = 1'b0;
          end
          5'd13: cmd = mk(kpsf_pkg::U_MUL, kpsf_pkg::S_REG, kpsf_pkg::R_D,
                          kpsf_pkg::S_REG, pm ? kpsf_pkg::R_PP : kpsf_pkg::R_PS,
                          kpsf_pkg::R_H);
          5'd14: cmd = mk(kpsf_pkg::U_SUB, kpsf_pkg::S_REG, kpsf_pkg::R_SP,
                          kpsf_pkg::S_REG, kpsf_pkg::R_H, kpsf_pkg::R_H);
          5'd15: cmd = mk(kpsf_pkg::U_MUL, kpsf_pkg::S_REG, kpsf_pkg::R_D,
                          kpsf_pkg::S_REG, pm ? kpsf_pkg::R_PS : kpsf_pkg::R_SS,
                          kpsf_pkg::R_E);
          5'd16: cmd = mk(kpsf_pkg::U_SUB, kpsf_pkg::S_REG, kpsf_pkg::R_SS,
                          kpsf_pkg::S_REG, kpsf_pkg::R_E, kpsf_pkg::R_SS);
          5'd17: cmd = mk(kpsf_pkg::U_MOV, kpsf_pkg::S_REG, kpsf_pkg::R_F,
                          kpsf_pkg::S_REG, kpsf_pkg::R_A, kpsf_pkg::R_PP);
          5'd18: cmd = mk(kpsf_pkg::U_MOV, kpsf_pkg::S_REG, kpsf_pkg::R_G,
                          kpsf_pkg::S_REG, kpsf_pkg::R_A, kpsf_pkg::R_PS);
          5'd19: begin
            cmd = mk(kpsf_pkg::U_MOV, kpsf_pkg::S_REG, kpsf_pkg::R_H,
                     kpsf_pkg::S_REG, kpsf_pkg::R_A, kpsf_pkg::R_SP);
            last = 1'b1;
          end
          default: last = 1'b1;
        endcase
      end
      default: last = 1'b1;
    endcase
    if (st_r != ST_RUN) begin
      cmd = '0; cmd.uop = kpsf_pkg::U_NONE; last = 1'b0;
    end
    if (st_r == ST_IDLE && start) cmd.sat_clr = 1'b1;
  end

  assign isdiv = cmd.go && cmd.uop == kpsf_pkg::U_DIV;

  always_comb begin
    st_nxt = st_r; pc_nxt = pc_r; op_nxt = op_r;
    case (st_r)
      ST_IDLE: if (start) begin
        st_nxt = ST_RUN; pc_nxt = '0; op_nxt = op;
      end
      ST_RUN: begin
        pc_nxt = pc_r + 5'd1;
        if (last) st_nxt = ST_DONE;
        else if (isdiv) st_nxt = ST_WAIT;
      end
      ST_WAIT: if (!stat.busy) st_nxt = ST_RUN;
      ST_DONE: st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign idle = (st_r == ST_IDLE);
  assign finish = (st_r == ST_DONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      pc_r <= '0;
      op_r <= kpsf_pkg::OP_PREDICT;
    end else begin
      st_r <= st_nxt;
      pc_r <= pc_nxt;
      op_r <= op_nxt;
    end
  end
endmodule

>>> rtl/core/kalman_position_speed_filter_unit.sv
// top level of the two-state position and speed filter
// updates run two serial divisions of a 48-bit quotient, which are skipped when s is zero
// op code 3 leaves the estimates unchanged but clears the saturated flag
// throughput: one request at a time, next accepted once the result register is free
// the shared serial divider, one quotient bit per cycle, sets the update time
// synchronous active-low reset restores state and noise registers to defaults
module kalman_position_speed_filter_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [95:0]  in_tdata,  // value, dt, meas_noise
  input  logic [1:0]   in_tuser,  // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata, // est_position, est_speed, pos_variance, spd_variance
  output logic         out_tuser, // saturated
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_data
);
  logic [kpsf_pkg::CW-1:0] q_pos_r, q_spd_r;
  logic signed [kpsf_pkg::QW-1:0] val_r;
  logic [kpsf_pkg::QW-1:0] dt_r, rn_r;
  logic signed [kpsf_pkg::QW-1:0] o_pos, o_spd, o_pp, o_ss;
  logic o_clip, idle, finish, start, ov_r;
  kpsf_pkg::cmd_t cmd;
  kpsf_pkg::stat_t stat;

  assign in_tready = idle && !ov_r;
  assign start = in_tvalid && in_tready;

  kpsf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .op(in_tuser),
    .stat(stat), .cmd(cmd), .idle(idle), .finish(finish)
  );

  kpsf_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .val(val_r), .dt(dt_r), .rn(rn_r),
    .q_pos(q_pos_r), .q_spd(q_spd_r), .stat(stat),
    .o_pos(o_pos), .o_spd(o_spd), .o_pp(o_pp), .o_ss(o_ss), .o_clip(o_clip)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_pos_r <= kpsf_pkg::Q_POS_RST;
      q_spd_r <= kpsf_pkg::Q_SPD_RST;
      ov_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == kpsf_pkg::CFG_Q_POS) q_pos_r <= cfg_data;
      if (cfg_we && cfg_index == kpsf_pkg::CFG_Q_SPD) q_spd_r <= cfg_data;
      if (finish) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
    if (start) begin
      val_r <= in_tdata[31:0];
      dt_r <= in_tdata[63:32];
      rn_r <= in_tdata[95:64];
    end
    if (finish) begin
      out_tdata <= {o_ss, o_pp, o_spd, o_pos};
      out_tuser <= o_clip;
    end
  end

  assign out_tvalid = ov_r;
endmodule
